>>> hdl/odmm_pkg.sv
// Package: shared types and constants for the onset detector.
`default_nettype none
package odmm_pkg;
   localparam int SMOOTH_DEPTH_DEF  = 16;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int ENERGY_BITS_DEF   = 16;
   localparam int FRAC_BITS_DEF     = 8;
   localparam int K_FRAC            = 8;
   localparam logic [15:0] K_DEFAULT = 16'd77;
   localparam int MIN_STATS         = 8;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [CSR_ADDR_BITS-1:0] REG_ODF_MODE   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_THRESH_K   = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_REFRACTORY = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WARMUP     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SMOOTH_LEN = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HIST_LEN   = 3'd5;

   localparam logic [1:0] MODE_FLUX = 2'd0;
   localparam logic [1:0] MODE_RAW  = 2'd1;
   localparam logic [1:0] MODE_DIFF = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRE, ST_SUM, ST_DIV, ST_HWR, ST_CHK,
      ST_MED, ST_MAD, ST_THR, ST_DEC, ST_OUT
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic pre;       // frame prologue (counters, detect enable)
      logic sum_clr;   // write onset, clear sum
      logic sum_step;  // accumulate one window entry
      logic div_start;
      logic div_step;
      logic hist_wr;
      logic sel_start; // start a selection pass
      logic sel_step;
      logic sel_mad;   // pass works on deviations
      logic thr;       // form threshold
      logic dec;       // decide hit
      logic skip;      // detection off: decide with no hit
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic detect;
      logic sum_done;
      logic div_done;
      logic stats_ok;
      logic sel_done;
   } sts_type;
endpackage
`default_nettype wire

>>> hdl/odmm_ctrl.sv
// Controller: frame sequencing state machine.
`default_nettype none
module odmm_ctrl import odmm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    out_free,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         emit
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_PRE;
         ST_PRE:  state_in = sts.detect ? ST_SUM : ST_OUT;
         ST_SUM:  if (sts.sum_done) state_in = ST_DIV;
         ST_DIV:  if (sts.div_done) state_in = ST_HWR;
         ST_HWR:  state_in = ST_CHK;
         ST_CHK:  state_in = sts.stats_ok ? ST_MED : ST_THR;
         ST_MED:  if (sts.sel_done) state_in = ST_MAD;
         ST_MAD:  if (sts.sel_done) state_in = ST_THR;
         ST_THR:  state_in = ST_DEC;
         ST_DEC:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: cmd.pre = start;
         ST_PRE: begin
            cmd.sum_clr = sts.detect;
            cmd.skip    = !sts.detect;
         end
         ST_SUM: begin
            cmd.sum_step  = 1'b1;
            cmd.div_start = sts.sum_done;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         ST_HWR:  cmd.hist_wr = 1'b1;
         ST_CHK:  cmd.sel_start = sts.stats_ok;
         ST_MED: begin
            cmd.sel_step  = 1'b1;
            cmd.sel_start = sts.sel_done;
            cmd.sel_mad   = sts.sel_done;
         end
         ST_MAD: begin
            cmd.sel_step = 1'b1;
            cmd.sel_mad  = 1'b1;
         end
         ST_THR:  cmd.thr = 1'b1;
         ST_DEC:  cmd.dec = 1'b1;
         ST_OUT:  emit = out_free;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> hdl/odmm_dp.sv
// Datapath: smoothing, history, rank selection, threshold and hit decision.
`default_nettype none
module odmm_dp import odmm_pkg::*; #(
   parameter int SMOOTH_DEPTH  = SMOOTH_DEPTH_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int ENERGY_BITS   = ENERGY_BITS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire logic [ENERGY_BITS-1:0]   energy,
   input  wire cmd_type                  cmd,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output sts_type                       sts,
   output logic                          hit
);
   localparam int SPB = $clog2(SMOOTH_DEPTH);
   localparam int SCB = $clog2(SMOOTH_DEPTH + 1);
   localparam int HPB = $clog2(HISTORY_DEPTH);
   localparam int HCB = $clog2(HISTORY_DEPTH + 1);
   localparam int SUMB = ENERGY_BITS + SPB;
   localparam int SMB = ENERGY_BITS + FRAC_BITS; // smoothed width
   localparam int NUMB = SUMB + FRAC_BITS;
   localparam int THB = SMB + 17;

   // configuration
   logic [1:0]  mode_ff;
   logic [15:0] k_ff, refr_frames_ff, warm_ff;
   logic [4:0]  slen_raw_ff;
   logic [6:0]  hlen_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIFF; k_ff <= K_DEFAULT; refr_frames_ff <= '0;
         warm_ff <= '0; slen_raw_ff <= 5'd4; hlen_raw_ff <= 7'd32;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ODF_MODE:   mode_ff <= csr_wdata[1:0];
            REG_THRESH_K:   k_ff <= csr_wdata;
            REG_REFRACTORY: refr_frames_ff <= csr_wdata;
            REG_WARMUP:     warm_ff <= csr_wdata;
            REG_SMOOTH_LEN: slen_raw_ff <= csr_wdata[4:0];
            REG_HIST_LEN:   hlen_raw_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic [SCB-1:0] slen;
   logic [HCB-1:0] hlen;
   always_comb begin
      if (slen_raw_ff == '0) slen = SCB'(1);
      else if (32'(slen_raw_ff) > SMOOTH_DEPTH) slen = SCB'(SMOOTH_DEPTH);
      else slen = SCB'(slen_raw_ff);
      if (hlen_raw_ff == '0) hlen = HCB'(1);
      else if (32'(hlen_raw_ff) > HISTORY_DEPTH) hlen = HCB'(HISTORY_DEPTH);
      else hlen = HCB'(hlen_raw_ff);
   end

   // frame state
   logic [ENERGY_BITS-1:0] e_ff, prev_e_ff;
   logic [15:0] frames_ff, refr_ff;
   logic detect_ff, was_above_ff, hit_ff;
   logic [SMB-1:0] prev_sm_ff;

   logic [15:0] frames_inc;
   assign frames_inc = (frames_ff != 16'hFFFF) ? frames_ff + 16'd1 : frames_ff;

   // smoothing ring
   logic [ENERGY_BITS-1:0] sring [SMOOTH_DEPTH];
   logic [SPB-1:0] sptr_ff, sidx_ff;
   logic [SCB-1:0] scnt_ff, siter_ff;
   logic [SUMB-1:0] sum_ff;
   logic [ENERGY_BITS-1:0] rise, onset;
   logic [SCB-1:0] scnt_next;

   assign rise = (e_ff > prev_e_ff) ? e_ff - prev_e_ff : '0;
   always_comb begin
      if (mode_ff == MODE_RAW) onset = e_ff;
      else if (mode_ff == MODE_FLUX) onset = (scnt_ff >= SCB'(2)) ? rise : '0;
      else onset = (scnt_ff >= SCB'(1)) ? rise : '0;
      scnt_next = (scnt_ff + SCB'(1) > slen) ? slen : scnt_ff + SCB'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_clr) sring[sptr_ff] <= onset;
   end

   assign sts.sum_done = (siter_ff == scnt_ff) && !cmd.sum_clr;

   // restoring divider: numerator / count
   logic [NUMB-1:0] quo_ff;
   logic [SCB-1:0]  rem_ff;
   logic [$clog2(NUMB+1)-1:0] dcnt_ff;
   logic [SCB:0] rem_try;
   assign rem_try = {rem_ff, quo_ff[NUMB-1]};
   assign sts.div_done = (dcnt_ff == '0);

   // history ring
   logic [SMB-1:0] hring [HISTORY_DEPTH];
   logic [HPB-1:0] hptr_ff;
   logic [HCB-1:0] hcnt_ff, hcnt_next;
   logic [SMB-1:0] smoothed;
   assign smoothed = quo_ff[SMB-1:0];
   assign hcnt_next = (hcnt_ff + HCB'(1) > hlen) ? hlen : hcnt_ff + HCB'(1);
   assign sts.stats_ok = (hcnt_ff >= HCB'(MIN_STATS));

   always_ff @(posedge clock) begin
      if (cmd.hist_wr) hring[hptr_ff] <= smoothed;
   end

   // rank selection: for each candidate, count entries below / equal.
   // Candidate loop i over window, inner loop j; memory read registered.
   logic [HCB-1:0] ci_ff, cj_ff;
   logic [SMB-1:0] cand_ff, rd_ff;
   logic rd_v_ff;
   logic [HCB-1:0] lt_ff, le_ff;
   logic [SMB-1:0] lo_ff, hi_ff, med_ff;
   logic [SMB-1:0] cval, rval;
   logic loadcand_ff, seldone_ff;
   logic [HPB-1:0] raddr;
   int raddr_lin;
   logic [HCB-1:0] rank_lo, rank_hi;

   assign rank_hi = hcnt_ff >> 1;
   assign rank_lo = hcnt_ff[0] ? rank_hi : rank_hi - HCB'(1);

   function automatic logic [SMB-1:0] absdiff(input logic [SMB-1:0] a,
                                              input logic [SMB-1:0] b);
      absdiff = (a > b) ? a - b : b - a;
   endfunction

   // step back from the newest entry, wrapping at the ring depth
   always_comb begin
      raddr_lin = int'(hptr_ff) - 1 - int'(loadcand_ff ? ci_ff : cj_ff);
      if (raddr_lin < 0) raddr_lin = raddr_lin + HISTORY_DEPTH;
      raddr = HPB'(raddr_lin);
   end

   always_ff @(posedge clock) begin
      rd_ff <= hring[raddr];
   end

   assign cval = cmd.sel_mad ? absdiff(rd_ff, med_ff) : rd_ff;
   assign rval = cval;
   assign sts.sel_done = seldone_ff;

   logic [SMB:0] mid_sum;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // threshold
   logic [SMB-1:0] mad;
   logic [15:0] kk;
   logic [THB-1:0] thr_ff;
   assign mad = (mid_sum[SMB:1] == '0) ? SMB'(1) : mid_sum[SMB:1];
   assign kk = (k_ff != '0) ? k_ff : K_DEFAULT;

   logic above;
   assign above = THB'(smoothed) > thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_e_ff <= '0; frames_ff <= '0; refr_ff <= '0; detect_ff <= 1'b0;
         was_above_ff <= 1'b0; prev_sm_ff <= '0; hit_ff <= 1'b0;
         sptr_ff <= '0; scnt_ff <= '0; hptr_ff <= '0; hcnt_ff <= '0;
         siter_ff <= '0; dcnt_ff <= '0; seldone_ff <= 1'b0;
      end else begin
         seldone_ff <= 1'b0;
         if (load) begin
            e_ff <= energy;
            frames_ff <= frames_inc;
            if (refr_ff != '0) refr_ff <= refr_ff - 16'd1;
            if (frames_inc >= warm_ff) detect_ff <= 1'b1;
         end
         if (cmd.sum_clr) begin
            sptr_ff <= (32'(sptr_ff) == SMOOTH_DEPTH - 1) ? '0 : sptr_ff + SPB'(1);
            sidx_ff <= sptr_ff;
            scnt_ff <= scnt_next;
            siter_ff <= '0;
            sum_ff <= '0;
         end
         if (cmd.sum_step && !sts.sum_done) begin
            sum_ff <= sum_ff + SUMB'(sring[sidx_ff]);
            sidx_ff <= (sidx_ff == '0) ? SPB'(SMOOTH_DEPTH - 1) : sidx_ff - SPB'(1);
            siter_ff <= siter_ff + SCB'(1);
         end
         if (cmd.div_start) begin
            quo_ff <= {sum_ff, FRAC_BITS'(0)};
            rem_ff <= '0;
            dcnt_ff <= ($bits(dcnt_ff))'(NUMB);
         end
         if (cmd.div_step && !sts.div_done) begin
            if (rem_try >= {1'b0, scnt_ff}) rem_ff <= SCB'(rem_try - {1'b0, scnt_ff});
            else rem_ff <= rem_try[SCB-1:0];
            quo_ff <= {quo_ff[NUMB-2:0], rem_try >= {1'b0, scnt_ff}};
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         if (cmd.hist_wr) begin
            hptr_ff <= (32'(hptr_ff) == HISTORY_DEPTH - 1) ? '0 : hptr_ff + HPB'(1);
            hcnt_ff <= hcnt_next;
         end
         if (cmd.sel_start) begin
            if (cmd.sel_mad) med_ff <= mid_sum[SMB:1];
            ci_ff <= '0; cj_ff <= '0; loadcand_ff <= 1'b1; rd_v_ff <= 1'b0;
            lt_ff <= '0; le_ff <= '0;
         end else if (cmd.sel_step && !seldone_ff) begin
            // pipeline: address issued this cycle, data seen next
            if (loadcand_ff) begin
               loadcand_ff <= 1'b0;
               rd_v_ff <= 1'b0;
            end else if (!rd_v_ff && cj_ff == '0 && lt_ff == '0 && le_ff == '0) begin
               rd_v_ff <= 1'b1;
               cand_ff <= cval;
               cj_ff <= cj_ff + HCB'(1);
            end else begin
               if (rval < cand_ff) lt_ff <= lt_ff + HCB'(1);
               if (rval <= cand_ff) le_ff <= le_ff + HCB'(1);
               if (cj_ff == hcnt_ff) begin
                  // rank check with this entry's counts included
                  if (lt_ff + HCB'(rval < cand_ff) <= rank_lo &&
                      le_ff + HCB'(rval <= cand_ff) > rank_lo) lo_ff <= cand_ff;
                  if (lt_ff + HCB'(rval < cand_ff) <= rank_hi &&
                      le_ff + HCB'(rval <= cand_ff) > rank_hi) hi_ff <= cand_ff;
                  lt_ff <= '0; le_ff <= '0; cj_ff <= '0; rd_v_ff <= 1'b0;
                  if (ci_ff + HCB'(1) == hcnt_ff) seldone_ff <= 1'b1;
                  else begin
                     ci_ff <= ci_ff + HCB'(1);
                     loadcand_ff <= 1'b1;
                  end
               end else begin
                  cj_ff <= cj_ff + HCB'(1);
               end
            end
         end
         if (cmd.thr) begin
            if (hcnt_ff >= HCB'(MIN_STATS))
               thr_ff <= THB'(med_ff) + ((THB'(kk) * THB'(mad)) >> K_FRAC);
            else
               thr_ff <= THB'((32'(k_ff) << FRAC_BITS) >> K_FRAC);
         end
         if (cmd.dec) begin
            hit_ff <= above && !was_above_ff && (smoothed >= prev_sm_ff) &&
                      (refr_ff == '0);
            if (above && !was_above_ff && (smoothed >= prev_sm_ff) && refr_ff == '0)
               refr_ff <= refr_frames_ff;
            was_above_ff <= above;
            prev_sm_ff <= smoothed;
            prev_e_ff <= e_ff;
         end
         if (cmd.skip) begin
            hit_ff <= 1'b0;
            prev_e_ff <= e_ff;
         end
      end
   end

   assign sts.detect = detect_ff;
   assign hit = hit_ff;
endmodule
`default_nettype wire

>>> hdl/onset_detector_median_mad.sv
// Onset detector top level: each frame runs a prologue, then, once detection is
// enabled, the smoothing sum, division, history write, median and MAD selection
// passes (only with 8 or more history entries), threshold and decision, then output.
// The selection passes dominate. Frames do not overlap: the next energy transfer
// is taken once the previous hit has been handed to the result register.
// Reset: synchronous, active high; clears counters, pointers, flags and configuration.
`default_nettype none
module onset_detector_median_mad import odmm_pkg::*; #(
   parameter int SMOOTH_DEPTH  = SMOOTH_DEPTH_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int ENERGY_BITS   = ENERGY_BITS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [((ENERGY_BITS+7)/8)*8-1:0] req_tdata, // energy
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata, // hit
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   logic busy, emit, hit, start, out_free;
   logic rsp_valid_ff, rsp_hit_ff;

   // take a new frame only while idle
   assign req_tready = !busy;
   assign start = req_tvalid && req_tready;
   // result register frees when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   odmm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .out_free(out_free),
      .sts(sts), .cmd(cmd), .busy(busy), .emit(emit)
   );

   odmm_dp #(
      .SMOOTH_DEPTH(SMOOTH_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH),
      .ENERGY_BITS(ENERGY_BITS), .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .load(cmd.pre),
      .energy(req_tdata[ENERGY_BITS-1:0]), .cmd(cmd),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .sts(sts), .hit(hit)
   );

   // hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
         rsp_hit_ff <= hit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_hit_ff};
endmodule
`default_nettype wire
